// ===== design/bopl_pkg.sv =====
package bopl_pkg;

  // Default sizing of the bank
  localparam int NUM_LISTS_DEF     = 16;
  localparam int LIST_CAPACITY_DEF = 1024;
  localparam int COORD_BITS_DEF    = 16;

  // Request codes as they arrive on the port
  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_READ   = 3'd1,
    KIND_WRITE  = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_REMOVE = 3'd4,
    KIND_FIND   = 3'd5,
    KIND_LENGTH = 3'd6,
    KIND_NOP    = 3'd7
  } kind_e;

  // Classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_APPEND,
    OP_READ,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE,
    OP_FIND,
    OP_LENGTH,
    OP_IGNORE
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_MOVE,
    ST_DRAIN,
    ST_PLACE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  list_id;
    logic [9:0]  position;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
  } req_t;

  typedef struct packed {
    logic [15:0] point_col;
    logic [15:0] point_row;
    logic        match_found;
    logic [9:0]  match_position;
    logic [10:0] list_length;
    logic        full_refused;
  } res_t;

  typedef struct packed {
    op_e         op;
    logic [3:0]  list_id;
    logic [9:0]  position;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  vld;
    item_t item;
  } qhead_t;

endpackage

// ===== design/bopl_ram.sv =====
module bopl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bopl_front.sv =====
module bopl_front #(
  parameter int NUM_LISTS = bopl_pkg::NUM_LISTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bopl_pkg::req_t    req_i,
  output bopl_pkg::qhead_t  head_o,
  input  logic              pop_i
);

  bopl_pkg::item_t fifo_q [2];
  logic            wp_q, wp_d, rp_q, rp_d;
  logic [1:0]      fill_q, fill_d;
  logic            push;
  bopl_pkg::item_t cls;

  // Classify the incoming word
  always_comb begin
    cls.list_id  = req_i.list_id;
    cls.position = req_i.position;
    cls.coord_x  = req_i.coord_x;
    cls.coord_y  = req_i.coord_y;
    case (bopl_pkg::kind_e'(req_i.kind))
      bopl_pkg::KIND_APPEND: cls.op = bopl_pkg::OP_APPEND;
      bopl_pkg::KIND_READ:   cls.op = bopl_pkg::OP_READ;
      bopl_pkg::KIND_WRITE:  cls.op = bopl_pkg::OP_WRITE;
      bopl_pkg::KIND_INSERT: cls.op = bopl_pkg::OP_INSERT;
      bopl_pkg::KIND_REMOVE: cls.op = bopl_pkg::OP_REMOVE;
      bopl_pkg::KIND_FIND:   cls.op = bopl_pkg::OP_FIND;
      default:               cls.op = bopl_pkg::OP_LENGTH;
    endcase
    if (32'(req_i.list_id) >= NUM_LISTS) begin
      cls.op = bopl_pkg::OP_IGNORE;
    end
  end

  assign busy = (fill_q == 2'd2);
  assign push = start && !busy;

  // Advance pointers and fill level
  always_comb begin
    wp_d   = push  ? ~wp_q : wp_q;
    rp_d   = pop_i ? ~rp_q : rp_q;
    fill_d = fill_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= cls;
    end
  end

  assign head_o.vld  = (fill_q != 2'd0);
  assign head_o.item = fifo_q[rp_q];

endmodule

// ===== design/bopl_back.sv =====
module bopl_back #(
  parameter int NUM_LISTS     = bopl_pkg::NUM_LISTS_DEF,
  parameter int LIST_CAPACITY = bopl_pkg::LIST_CAPACITY_DEF,
  parameter int COORD_BITS    = bopl_pkg::COORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bopl_pkg::qhead_t head_i,
  output logic             pop_o,
  output bopl_pkg::res_t   res_o,
  output logic             res_valid_o
);

  localparam int IW    = $clog2(LIST_CAPACITY);
  localparam int CW    = $clog2(LIST_CAPACITY + 1);
  localparam int PW    = (CW > 10) ? CW : 10;
  localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int DEPTH = NUM_LISTS * LIST_CAPACITY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = 2 * COORD_BITS;

  bopl_pkg::state_e state_q, state_d;
  bopl_pkg::item_t  item_q, item_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    src_q, src_d, pdst_q, pdst_d;
  logic             pend_q, pend_d, more_q, more_d;
  bopl_pkg::res_t   res_q, res_d;
  logic             res_vld_q, res_vld_d;
  logic [CW-1:0]    counts_q [NUM_LISTS];

  logic             we, re;
  logic [IW-1:0]    w_idx, r_idx;
  logic [DW-1:0]    wdata, rdata, new_pt;
  logic [AW-1:0]    base;
  logic             fin, cnt_we;
  logic [CW-1:0]    fin_cnt;
  logic [LW-1:0]    lid_idx, head_lid;
  logic             pos_lt, full, rm_tail, move_last, hit, is_ins;

  assign lid_idx  = LW'(item_q.list_id);
  assign head_lid = LW'(head_i.item.list_id);
  assign base     = AW'(item_q.list_id) * AW'(LIST_CAPACITY);
  assign new_pt   = {COORD_BITS'(item_q.coord_x), COORD_BITS'(item_q.coord_y)};
  assign pos_lt   = PW'(item_q.position) < PW'(cnt_q);
  assign full     = cnt_q >= CW'(LIST_CAPACITY);
  assign rm_tail  = (PW'(item_q.position) + PW'(1)) == PW'(cnt_q);
  assign is_ins   = (item_q.op == bopl_pkg::OP_INSERT);
  assign move_last = is_ins ? (src_q == IW'(item_q.position)) : (src_q == IW'(cnt_q));
  assign hit      = (rdata == new_pt);

  bopl_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (base + AW'(w_idx)),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (base + AW'(r_idx)),
    .rdata_o (rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bopl_pkg::ST_IDLE: if (head_i.vld) state_d = bopl_pkg::ST_EXEC;
      bopl_pkg::ST_EXEC: begin
        case (item_q.op)
          bopl_pkg::OP_INSERT: state_d = (!full && pos_lt) ? bopl_pkg::ST_MOVE
                                                           : bopl_pkg::ST_IDLE;
          bopl_pkg::OP_READ:   state_d = pos_lt ? bopl_pkg::ST_READ : bopl_pkg::ST_IDLE;
          bopl_pkg::OP_REMOVE: state_d = (pos_lt && !rm_tail) ? bopl_pkg::ST_MOVE
                                                              : bopl_pkg::ST_IDLE;
          bopl_pkg::OP_FIND:   state_d = (cnt_q == '0) ? bopl_pkg::ST_IDLE
                                                       : bopl_pkg::ST_SCAN;
          default:             state_d = bopl_pkg::ST_IDLE;
        endcase
      end
      bopl_pkg::ST_MOVE:  if (move_last) state_d = bopl_pkg::ST_DRAIN;
      bopl_pkg::ST_DRAIN: state_d = is_ins ? bopl_pkg::ST_PLACE : bopl_pkg::ST_IDLE;
      bopl_pkg::ST_SCAN:  if (pend_q && (hit || !more_q)) state_d = bopl_pkg::ST_IDLE;
      default:            state_d = bopl_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    item_d  = item_q;
    cnt_d   = cnt_q;
    src_d   = src_q;
    pdst_d  = pdst_q;
    pend_d  = 1'b0;
    more_d  = more_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    w_idx   = IW'(item_q.position);
    r_idx   = IW'(item_q.position);
    wdata   = new_pt;
    fin     = 1'b0;
    fin_cnt = cnt_q;
    res_d   = '0;
    case (state_q)
      bopl_pkg::ST_IDLE: begin
        if (head_i.vld) begin
          pop_o  = 1'b1;
          item_d = head_i.item;
          cnt_d  = (head_i.item.op == bopl_pkg::OP_IGNORE) ? '0 : counts_q[head_lid];
        end
      end
      bopl_pkg::ST_EXEC: begin
        case (item_q.op)
          bopl_pkg::OP_APPEND, bopl_pkg::OP_INSERT: begin
            if (full) begin
              fin = 1'b1;
              res_d.full_refused = 1'b1;
            end else if (is_ins && pos_lt) begin
              src_d = IW'(cnt_q - CW'(1));
            end else begin
              we      = 1'b1;
              w_idx   = IW'(cnt_q);
              fin     = 1'b1;
              fin_cnt = cnt_q + CW'(1);
            end
          end
          bopl_pkg::OP_READ: begin
            re  = pos_lt;
            fin = !pos_lt;
          end
          bopl_pkg::OP_WRITE: begin
            we  = pos_lt;
            fin = 1'b1;
          end
          bopl_pkg::OP_REMOVE: begin
            if (pos_lt) begin
              cnt_d   = cnt_q - CW'(1);
              fin_cnt = cnt_q - CW'(1);
              src_d   = IW'(item_q.position) + IW'(1);
            end
            fin = !pos_lt || rm_tail;
          end
          bopl_pkg::OP_FIND: begin
            src_d  = '0;
            more_d = 1'b1;
            fin    = (cnt_q == '0);
          end
          default: fin = 1'b1;
        endcase
      end
      bopl_pkg::ST_READ: begin
        fin             = 1'b1;
        res_d.point_col = 16'(rdata[DW-1:COORD_BITS]);
        res_d.point_row = 16'(rdata[COORD_BITS-1:0]);
      end
      bopl_pkg::ST_MOVE: begin
        // Read the next source while the previous one lands one slot over
        re     = 1'b1;
        r_idx  = src_q;
        pend_d = 1'b1;
        pdst_d = is_ins ? src_q + IW'(1) : src_q - IW'(1);
        src_d  = is_ins ? src_q - IW'(1) : src_q + IW'(1);
        we     = pend_q;
        w_idx  = pdst_q;
        wdata  = rdata;
      end
      bopl_pkg::ST_DRAIN: begin
        we    = 1'b1;
        w_idx = pdst_q;
        wdata = rdata;
        fin   = !is_ins;
      end
      bopl_pkg::ST_PLACE: begin
        we      = 1'b1;
        fin     = 1'b1;
        fin_cnt = cnt_q + CW'(1);
      end
      bopl_pkg::ST_SCAN: begin
        if (more_q) begin
          re     = 1'b1;
          r_idx  = src_q;
          pend_d = 1'b1;
          pdst_d = src_q;
          src_d  = src_q + IW'(1);
          more_d = (src_q != IW'(cnt_q - CW'(1)));
        end
        if (pend_q && (hit || !more_q)) begin
          fin                  = 1'b1;
          res_d.match_found    = hit;
          res_d.match_position = hit ? 10'(pdst_q) : 10'd0;
        end
      end
      default: ;
    endcase
    if (item_q.op != bopl_pkg::OP_IGNORE) begin
      res_d.list_length = 11'(fin_cnt);
    end
    if (!fin) begin
      res_d = '0;
    end
    cnt_we    = fin && (item_q.op != bopl_pkg::OP_IGNORE);
    res_vld_d = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bopl_pkg::ST_IDLE;
      pend_q    <= 1'b0;
      more_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      more_q    <= more_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cnt_q  <= cnt_d;
    src_q  <= src_d;
    pdst_q <= pdst_d;
    res_q  <= res_d;
  end

  // Hold the per-list lengths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) counts_q[i] <= '0;
    end else if (cnt_we) begin
      counts_q[lid_idx] <= fin_cnt;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> state_q == bopl_pkg::ST_IDLE)
    else $error("result strobe outside idle");
  a_move_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bopl_pkg::ST_MOVE |->
      (item_q.op == bopl_pkg::OP_INSERT || item_q.op == bopl_pkg::OP_REMOVE))
    else $error("shift without insert or remove");
  a_drain_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bopl_pkg::ST_DRAIN |-> pend_q)
    else $error("drain without pending word");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == bopl_pkg::ST_EXEC)
    else $error("pop did not start execution");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> fin_cnt <= CW'(LIST_CAPACITY))
    else $error("length beyond capacity");

endmodule

// ===== design/banked_ordered_point_lists.sv =====
// Each accepted word runs alone in the back end: append, overwrite and length finish in the
// execute state, a read goes on through a read state, an insert or remove shifts its entries
// one at a time, and a find scans until a hit or the list end; every word yields one result.
// Throughput: one request at a time in the back end; a two-word queue takes words ahead.
// Reset: all list lengths clear at once; stored points stay undefined until written.
// Results cannot be stalled: each appears for exactly one cycle on res_valid_o.
module banked_ordered_point_lists #(
  parameter int NUM_LISTS     = bopl_pkg::NUM_LISTS_DEF,
  parameter int LIST_CAPACITY = bopl_pkg::LIST_CAPACITY_DEF,
  parameter int COORD_BITS    = bopl_pkg::COORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bopl_pkg::req_t req_i,
  output bopl_pkg::res_t res_o,
  output logic           res_valid_o
);

  bopl_pkg::qhead_t head;
  logic             pop;

  bopl_front #(
    .NUM_LISTS (NUM_LISTS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .head_o (head),
    .pop_i  (pop)
  );

  bopl_back #(
    .NUM_LISTS     (NUM_LISTS),
    .LIST_CAPACITY (LIST_CAPACITY),
    .COORD_BITS    (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import bopl_pkg::*;

  localparam int LISTS = NUM_LISTS_DEF;
  localparam int CAP   = LIST_CAPACITY_DEF;

  typedef struct {
    req_t req;
    bit   drain;
  } send_word_t;

  typedef struct {
    res_t res;
    int   cyc;
  } want_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  res_t res_o;
  logic res_valid_o;

  send_word_t send_q[$];
  want_word_t want_q[$];
  logic [31:0] pts[LISTS][CAP];
  int unsigned pt_len[LISTS];
  int gen_len[LISTS];
  logic [15:0] coord_pool[8];
  int cyc_cnt = 0;
  int accepted = 0;
  int errors = 0;

  banked_ordered_point_lists u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cyc_cnt, msg);
    errors++;
  endtask

  // Compute the result word of one request and update the shadow lists
  function automatic res_t point_list_result(input req_t r);
    res_t o;
    kind_e k;
    int unsigned n;
    int unsigned p;
    int i;
    o = '0;
    k = kind_e'(r.kind);
    n = pt_len[r.list_id];
    p = r.position;
    case (k)
      KIND_APPEND, KIND_INSERT: begin
        if (n >= CAP) begin
          o.full_refused = 1'b1;
        end else if (k == KIND_INSERT && p < n) begin
          for (i = n; i > p; i--) pts[r.list_id][i] = pts[r.list_id][i-1];
          pts[r.list_id][p] = {r.coord_x, r.coord_y};
          n++;
        end else begin
          pts[r.list_id][n] = {r.coord_x, r.coord_y};
          n++;
        end
      end
      KIND_READ: begin
        if (p < n) {o.point_col, o.point_row} = pts[r.list_id][p];
      end
      KIND_WRITE: begin
        if (p < n) pts[r.list_id][p] = {r.coord_x, r.coord_y};
      end
      KIND_REMOVE: begin
        if (p < n) begin
          n--;
          for (i = p; i < n; i++) pts[r.list_id][i] = pts[r.list_id][i+1];
        end
      end
      KIND_FIND: begin
        for (i = 0; i < n; i++) begin
          if (pts[r.list_id][i] == {r.coord_x, r.coord_y}) begin
            o.match_found = 1'b1;
            o.match_position = i[9:0];
            break;
          end
        end
      end
      default: ;
    endcase
    pt_len[r.list_id] = n;
    o.list_length = n[10:0];
    return o;
  endfunction

  // Driver: predict on accept, then offer the next word or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      if (start && !busy) begin
        want_q.push_back('{point_list_result(req_i), cyc_cnt});
        accepted++;
      end
      if (!start || !busy) begin
        if (send_q.size() != 0 && !(send_q[0].drain && want_q.size() != 0) &&
            !((accepted < 300 || accepted > 500) && $urandom_range(99) < 16)) begin
          start <= 1'b1;
          req_i <= send_q[0].req;
          send_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (want_q.size() == 0 || want_q[0].cyc == cyc_cnt) begin
        report("result with no request pending");
      end else begin
        if (res_o.point_col !== want_q[0].res.point_col)
          report($sformatf("point_col %h want %h", res_o.point_col,
                           want_q[0].res.point_col));
        if (res_o.point_row !== want_q[0].res.point_row)
          report($sformatf("point_row %h want %h", res_o.point_row,
                           want_q[0].res.point_row));
        if (res_o.match_found !== want_q[0].res.match_found)
          report($sformatf("match_found %b want %b", res_o.match_found,
                           want_q[0].res.match_found));
        if (res_o.match_position !== want_q[0].res.match_position)
          report($sformatf("match_position %0d want %0d", res_o.match_position,
                           want_q[0].res.match_position));
        if (res_o.list_length !== want_q[0].res.list_length)
          report($sformatf("list_length %0d want %0d", res_o.list_length,
                           want_q[0].res.list_length));
        if (res_o.full_refused !== want_q[0].res.full_refused)
          report($sformatf("full_refused %b want %b", res_o.full_refused,
                           want_q[0].res.full_refused));
        void'(want_q.pop_front());
      end
    end
  end

  // Queue one request word and track list lengths for later picks
  task automatic add(input kind_e k, input int l, input int p, input logic [15:0] x,
                     input logic [15:0] y, input bit drain = 1'b0);
    send_word_t w;
    w.req = '{kind: k, list_id: l[3:0], position: p[9:0], coord_x: x, coord_y: y};
    w.drain = drain;
    send_q.push_back(w);
    case (k)
      KIND_APPEND: if (gen_len[l] < CAP) gen_len[l]++;
      KIND_INSERT: if (gen_len[l] < CAP) gen_len[l]++;
      KIND_REMOVE: if (p < gen_len[l]) gen_len[l]--;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_coord();
    return ($urandom_range(9) < 7) ? coord_pool[$urandom_range(7)]
                                   : 16'($urandom);
  endfunction

  initial begin
    int l;
    int p;
    int r;
    for (int i = 0; i < 8; i++) coord_pool[i] = 16'($urandom);
    coord_pool[0] = 16'h0000;
    coord_pool[1] = 16'hffff;

    // Directed: empty list, extremes, every kind, out-of-range cases
    add(KIND_LENGTH, 0, 0, 0, 0);
    add(KIND_READ, 0, 0, 0, 0);
    add(KIND_REMOVE, 0, 0, 0, 0);
    add(KIND_FIND, 0, 0, 0, 0);
    add(KIND_WRITE, 0, 0, 16'h1234, 16'h5678);
    add(KIND_APPEND, 0, 0, 16'h0000, 16'h0000);
    add(KIND_APPEND, 0, 0, 16'hffff, 16'hffff);
    add(KIND_INSERT, 0, 0, 16'haaaa, 16'h5555);
    add(KIND_INSERT, 0, 1023, 16'h5555, 16'haaaa);
    add(KIND_INSERT, 0, 2, 16'h0f0f, 16'hf0f0);
    add(KIND_READ, 0, 0, 0, 0);
    add(KIND_READ, 0, 3, 0, 0);
    add(KIND_READ, 0, 1023, 0, 0);
    add(KIND_WRITE, 0, 1, 16'hffff, 16'h0000);
    add(KIND_WRITE, 0, 700, 16'h1111, 16'h2222);
    add(KIND_FIND, 0, 0, 16'hffff, 16'h0000);
    add(KIND_FIND, 0, 0, 16'h5555, 16'haaaa);
    add(KIND_FIND, 0, 0, 16'h1357, 16'h2468);
    add(KIND_REMOVE, 0, 1, 0, 0);
    add(KIND_REMOVE, 0, 512, 0, 0);
    add(KIND_NOP, 0, 1023, 16'hffff, 16'hffff);
    add(KIND_APPEND, 15, 0, 16'h8000, 16'h0001);
    add(KIND_LENGTH, 15, 0, 0, 0);

    // Grow one list, then hit it with long shifts from the front and with requests at the tail
    for (int i = 0; i < 64; i++) add(KIND_APPEND, 9, 0, 16'($urandom), 16'(i));
    add(KIND_APPEND, 9, 0, 16'h1, 16'h2, 1'b1);
    add(KIND_INSERT, 9, 0, 16'h3, 16'h4);
    add(KIND_READ, 9, 65, 0, 0);
    add(KIND_FIND, 9, 0, 16'h0000, 16'h1234);
    add(KIND_REMOVE, 9, 0, 0, 0);
    add(KIND_INSERT, 9, 0, 16'hbeef, 16'hcafe);
    add(KIND_FIND, 9, 0, 16'hbeef, 16'hcafe);
    add(KIND_REMOVE, 9, 65, 0, 0);
    add(KIND_INSERT, 9, 1023, 16'h7777, 16'h8888);
    add(KIND_READ, 9, 65, 0, 0);
    add(KIND_REMOVE, 9, 20, 0, 0);

    // Random: mostly growing lists with in-range positions, some noise
    for (int i = 0; i < 480; i++) begin
      l = (i % 97 == 0) ? 9 : $urandom_range(7);
      r = $urandom_range(99);
      p = (gen_len[l] > 0 && $urandom_range(9) < 8) ? $urandom_range(gen_len[l] - 1)
                                                    : $urandom_range(1023);
      if (r < 30) add(KIND_APPEND, l, $urandom_range(1023), pick_coord(), pick_coord());
      else if (r < 45) add(KIND_READ, l, p, 16'($urandom), 16'($urandom));
      else if (r < 55) add(KIND_WRITE, l, p, pick_coord(), pick_coord());
      else if (r < 70) add(KIND_INSERT, l, p, pick_coord(), pick_coord());
      else if (r < 80) add(KIND_REMOVE, l, p, 16'($urandom), 16'($urandom));
      else if (r < 93) add(KIND_FIND, l, p, pick_coord(), pick_coord());
      else if (r < 97) add(KIND_LENGTH, $urandom_range(15), p, 0, 0);
      else add(KIND_NOP, l, p, 16'($urandom), 16'($urandom));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until everything is sent and answered, then let the block settle
    while (send_q.size() != 0 || start || want_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(8 * 4000000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bopl_pkg.sv
design/bopl_ram.sv
design/bopl_front.sv
design/bopl_back.sv
design/banked_ordered_point_lists.sv
tb/tb_top.sv
